// ===== rtl/core/stbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int DATA_W              = 32;
   localparam int CMD_W               = 2;
   localparam int POS_W               = 10;
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   // item command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic do_clear;
      logic do_append;
      logic start;    // latch target, open the full range
      logic probe;    // read the midpoint entry
      logic step;     // narrow the range after a miss
      logic post;     // load the result register
      logic post_hit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic range_empty;
      logic hit;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/stbs_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_chan_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface stbs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stbs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_datapath
// Entry memory, fill count, search bounds, compare and result register.
// ----------------------------------------------------------------------------
module stbs_datapath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire stbs_pkg::ctrl_cmd_type                ctrl,
   input  wire logic signed [stbs_pkg::DATA_W-1:0]    req_value,
   output      stbs_pkg::dp_status_type               status,
   output      stbs_pkg::rsp_item_type                rsp_item
);
   import stbs_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int BW = CW + 1;
   localparam logic signed [BW-1:0] ONE_S = BW'(1);

   logic signed [DATA_W-1:0] entries_mem [TABLE_DEPTH];

   logic [CW-1:0]            count_ff, count_in;
   logic signed [BW-1:0]     low_ff, low_in;
   logic signed [BW-1:0]     high_ff, high_in;
   logic [IW-1:0]            mid_ff;
   logic signed [DATA_W-1:0] target_ff;
   logic signed [DATA_W-1:0] rd_ff;
   rsp_item_type             rsp_ff;

   logic                     full;
   logic [BW:0]              mid_sum;
   logic signed [BW-1:0]     mid_s;
   logic                     less;

   assign full    = (count_ff == CW'(TABLE_DEPTH));
   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};   // bounds are >= 0 when probing
   assign mid_s   = signed'(BW'(mid_ff));
   assign less    = (target_ff < rd_ff);

   assign status.range_empty = (low_ff > high_ff);
   assign status.hit         = (rd_ff == target_ff);
   assign rsp_item           = rsp_ff;

   always_comb begin
      count_in = count_ff;
      if (ctrl.do_clear) begin
         count_in = '0;
      end else if (ctrl.do_append && !full) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (ctrl.start) begin
         low_in  = '0;
         high_in = signed'(BW'(count_ff)) - ONE_S;
      end else if (ctrl.step) begin
         if (less) begin
            high_in = mid_s - ONE_S;
         end else begin
            low_in = mid_s + ONE_S;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      if (ctrl.start) begin
         target_ff <= req_value;
      end
      if (ctrl.probe) begin
         mid_ff <= mid_sum[IW:1];
      end
      if (ctrl.post) begin
         rsp_ff.found    <= ctrl.post_hit;
         rsp_ff.position <= ctrl.post_hit ? POS_W'(mid_ff) : '0;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.do_append && !full) begin
         entries_mem[count_ff[IW-1:0]] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.probe) begin
         rd_ff <= entries_mem[mid_sum[IW:1]];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/stbs_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_controller
// Sequencer for item intake, bisection steps and result handoff.
// ----------------------------------------------------------------------------
module stbs_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [stbs_pkg::CMD_W-1:0]    req_cmd,
   output      logic                          req_ready,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire stbs_pkg::dp_status_type       status,
   output      stbs_pkg::ctrl_cmd_type        ctrl
);
   import stbs_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_CMP   = 2'd2;
   localparam logic [1:0] S_POST  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       hit_ff, hit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctrl.do_clear  = (req_cmd == CMD_CLEAR);
               ctrl.do_append = (req_cmd == CMD_APPEND);
               if (req_cmd == CMD_SEARCH) begin
                  ctrl.start = 1'b1;
                  state_in   = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (status.range_empty) begin
               hit_in   = 1'b0;
               state_in = S_POST;
            end else begin
               ctrl.probe = 1'b1;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            if (status.hit) begin
               hit_in   = 1'b1;
               state_in = S_POST;
            end else begin
               ctrl.step = 1'b1;
               state_in  = S_PROBE;
            end
         end
         S_POST: begin
            if (out_free) begin
               ctrl.post     = 1'b1;
               ctrl.post_hit = hit_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed 32-bit entries, filled by items and searched by bisection.
// ----------------------------------------------------------------------------
// A clear item empties the table and an append item writes the next entry;
// both give no result, and an append to a full table is dropped. A search
// item bisects entries 0..count-1 with midpoint floor((low+high)/2) and
// returns one result: found with the matching index (low 10 bits), or not
// found with position 0. Each probe is a registered read of the entry memory
// followed by the compare and bound update, and a search stops early on a
// hit. The next item is taken once the block is back in idle; a finished
// result sits in an output register, so intake continues while it waits,
// and only a following search holds at its end until that result is taken.
// The entry memory has no reset; only entries below the fill count are
// ever read.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   stbs_chan_if.sink   req_if,
   stbs_chan_if.source rsp_if
);
   import stbs_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type status;
   rsp_item_type  rsp_item;
   req_item_type  req_item;

   assign req_item = req_if.payload;

   // sequencer: intake, probe/compare loop, result handoff
   stbs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_item.cmd),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // entry memory, fill count, bounds and result register
   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_value (req_item.value),
      .status    (status),
      .rsp_item  (rsp_item)
   );

   assign rsp_if.payload = rsp_item;

endmodule

`default_nettype wire
